>>> sv/irdx_pkg.sv
// ----------------------------------------------------------------------------
// irdx_pkg
// Shared types, constants and helpers for the integer to radix text converter.
// ----------------------------------------------------------------------------
package irdx_pkg;

    localparam int VALUE_BITS = 32;
    localparam int RADIX_W    = 6;
    localparam int DIGIT_W    = 6;
    localparam int CHAR_W     = 7;
    localparam int CNT_W      = $clog2(VALUE_BITS);
    localparam int ND_W       = $clog2(VALUE_BITS + 1);

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [RADIX_W-1:0]    radix_t;
    typedef logic [DIGIT_W-1:0]    digit_t;
    typedef logic [CHAR_W-1:0]     char_t;

    localparam radix_t RADIX_MIN   = radix_t'(2);
    localparam radix_t RADIX_MAX   = radix_t'(36);
    localparam radix_t RADIX_RESET = radix_t'(10);

    localparam char_t ASCII_ZERO     = char_t'(48);
    localparam char_t ASCII_MINUS    = char_t'(45);
    localparam char_t ASCII_LETTER_A = char_t'(65);
    localparam digit_t DECIMAL_DIGITS = digit_t'(10);

    typedef struct packed {
        logic   start;
        value_t dividend;
        radix_t divisor;
    } div_req_t;

    typedef struct packed {
        logic   done;
        value_t quotient;
        digit_t remainder;
    } div_result_t;

    function automatic radix_t eff_radix(radix_t r);
        radix_t res;
        res = r;
        if (r < RADIX_MIN)
        begin
            res = RADIX_MIN;
        end
        else if (r > RADIX_MAX)
        begin
            res = RADIX_MAX;
        end
        return res;
    endfunction

    function automatic char_t digit_char(digit_t d);
        char_t res;
        if (d < DECIMAL_DIGITS)
        begin
            res = ASCII_ZERO + char_t'(d);
        end
        else
        begin
            res = ASCII_LETTER_A + char_t'(d - DECIMAL_DIGITS);
        end
        return res;
    endfunction

endpackage

>>> sv/integer_to_radix_digits.sv
// ----------------------------------------------------------------------------
// integer_to_radix_digits
// Converts a signed integer to its ASCII text in a configurable radix,
// one character per output request, sign first, most significant digit first.
//
//   channel   direction  handshake               payload
//   value     in         value_valid/value_stall value
//   char      out        char_valid/char_stall   char_code, last
//   cfg       in         cfg_valid/cfg_ready     cfg_data (radix)
//
// Each digit costs one pass of the shared divider.
// value_stall is high from acceptance until the last character is loaded.
// Output stalls hold the character register and pause emission.
// Reset sets the radix to 10 and leaves the block idle with no output.
// ----------------------------------------------------------------------------
module integer_to_radix_digits
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 value_valid,
    output logic                                 value_stall,
    input  logic signed [irdx_pkg::VALUE_BITS-1:0] value,
    output logic                                 char_valid,
    input  logic                                 char_stall,
    output irdx_pkg::char_t                      char_code,
    output logic                                 last,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  irdx_pkg::radix_t                     cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    localparam logic [irdx_pkg::ND_W-1:0] ND_ONE = irdx_pkg::ND_W'(1);

    logic [1:0]                  state_reg;
    logic [1:0]                  state_next;
    irdx_pkg::radix_t            radix_reg;
    logic                        neg_reg;
    logic                        neg_next;
    logic [irdx_pkg::ND_W-1:0]   nd_reg;
    logic [irdx_pkg::ND_W-1:0]   nd_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    irdx_pkg::char_t             out_char_reg;
    irdx_pkg::char_t             out_char_next;
    logic                        out_last_reg;
    logic                        out_last_next;
    irdx_pkg::digit_t            stack_reg [irdx_pkg::VALUE_BITS];

    irdx_pkg::div_req_t          div_req;
    irdx_pkg::div_result_t       div_res;
    irdx_pkg::value_t            mag;
    logic                        accept;
    logic                        push;
    logic                        pop;
    logic                        load;
    logic                        more;

    assign accept      = value_valid && (state_reg == S_IDLE);
    assign value_stall = (state_reg != S_IDLE);
    assign cfg_ready   = (state_reg == S_IDLE) && !value_valid;

    assign mag  = value[irdx_pkg::VALUE_BITS-1] ? irdx_pkg::value_t'(-value)
                                                 : irdx_pkg::value_t'(value);
    assign push = (state_reg == S_DIV) && div_res.done;
    assign more = (div_res.quotient != '0);
    assign load = (state_reg == S_EMIT) && (!out_valid_reg || !char_stall);
    assign pop  = load && !neg_reg;

    assign div_req.start    = accept || (push && more);
    assign div_req.dividend = accept ? mag : div_res.quotient;
    assign div_req.divisor  = irdx_pkg::eff_radix(radix_reg);

    irdx_divider u_divider
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (div_req),
        .result (div_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        nd_next        = nd_reg;
        out_valid_next = out_valid_reg && char_stall;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    neg_next   = value[irdx_pkg::VALUE_BITS-1];
                    nd_next    = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (push)
                begin
                    nd_next = nd_reg + 1'b1;
                    if (!more)
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_EMIT:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    if (neg_reg)
                    begin
                        out_char_next = irdx_pkg::ASCII_MINUS;
                        out_last_next = 1'b0;
                        neg_next      = 1'b0;
                    end
                    else
                    begin
                        out_char_next = irdx_pkg::digit_char(stack_reg[0]);
                        out_last_next = (nd_reg == ND_ONE);
                        nd_next       = nd_reg - 1'b1;
                        if (nd_reg == ND_ONE)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            radix_reg     <= irdx_pkg::RADIX_RESET;
            neg_reg       <= 1'b0;
            nd_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            neg_reg       <= neg_next;
            nd_reg        <= nd_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                radix_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    // digit stack: push at entry 0 while dividing, pop from entry 0 while emitting
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stack_reg[0] <= div_res.remainder;
            for (int i = 1; i < irdx_pkg::VALUE_BITS; i++)
            begin
                stack_reg[i] <= stack_reg[i-1];
            end
        end
        else if (pop)
        begin
            for (int i = 0; i < irdx_pkg::VALUE_BITS - 1; i++)
            begin
                stack_reg[i] <= stack_reg[i+1];
            end
        end
    end

    assign char_valid = out_valid_reg;
    assign char_code  = out_char_reg;
    assign last       = out_last_reg;

`ifndef SYNTHESIS
    a_nd_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nd_reg <= irdx_pkg::ND_W'(irdx_pkg::VALUE_BITS))
        else $error("digit count exceeds stack depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> nd_reg != '0)
        else $error("pop from empty digit stack");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> state_reg == S_DIV)
        else $error("divider finished outside divide phase");

    a_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_DIV && nd_reg == '0)
        else $error("accepted request did not start division");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> nd_reg != '0)
        else $error("emit phase with no digits");
`endif

endmodule

>>> sv/irdx_divider.sv
// ----------------------------------------------------------------------------
// irdx_divider
// Restoring shift-subtract divider, one quotient bit per cycle, by a small
// radix. Gives quotient and remainder with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module irdx_divider
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  irdx_pkg::div_req_t    req,
    output irdx_pkg::div_result_t result
);

    logic                       busy_reg;
    logic                       busy_next;
    logic                       done_reg;
    logic                       done_next;
    logic [irdx_pkg::CNT_W-1:0] count_reg;
    logic [irdx_pkg::CNT_W-1:0] count_next;
    irdx_pkg::value_t           quot_reg;
    irdx_pkg::value_t           quot_next;
    irdx_pkg::digit_t           rem_reg;
    irdx_pkg::digit_t           rem_next;
    irdx_pkg::radix_t           divisor_reg;
    irdx_pkg::radix_t           divisor_next;

    logic [irdx_pkg::DIGIT_W:0] trial;
    logic [irdx_pkg::DIGIT_W:0] diff;
    logic                       ge;

    assign trial = {rem_reg, quot_reg[irdx_pkg::VALUE_BITS-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign ge    = (trial >= {1'b0, divisor_reg});

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (req.start)
        begin
            busy_next    = 1'b1;
            count_next   = irdx_pkg::CNT_W'(irdx_pkg::VALUE_BITS - 1);
            quot_next    = req.dividend;
            rem_next     = '0;
            divisor_next = req.divisor;
        end
        else if (busy_reg)
        begin
            quot_next  = {quot_reg[irdx_pkg::VALUE_BITS-2:0], ge};
            rem_next   = ge ? diff[irdx_pkg::DIGIT_W-1:0] : trial[irdx_pkg::DIGIT_W-1:0];
            count_next = count_reg - 1'b1;
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign result.done      = done_reg;
    assign result.quotient  = quot_reg;
    assign result.remainder = rem_reg;

endmodule
